FILE: hw/rtl/qpa_pkg.sv
// package for the landing queue: field widths, codes, config resets
// and the structs passed between the sequencer and the top level
// no dependencies
`default_nettype none

package qpa_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 10;
    localparam int KIND_W      = 2;
    localparam int FUEL_W      = 7;
    localparam int EMG_W       = 2;
    localparam int MIN_W       = 10;
    localparam int BURN_W      = 4;
    localparam int THR_W       = 7;
    localparam int STATUS_W    = 2;
    localparam int DROP_W      = MIN_W + BURN_W;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    localparam logic [FUEL_W-1:0] FUEL_MAX  = 7'd100;
    localparam logic [BURN_W-1:0] BURN_RST  = 4'd2;
    localparam logic [THR_W-1:0]  THR_RST   = 7'd20;
    localparam logic [EMG_W-1:0]  EMG_NONE  = 2'd0;
    localparam logic [EMG_W-1:0]  EMG_LOW   = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_BURN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        K_ENQ  = 2'd0,
        K_DEQ  = 2'd1,
        K_PROM = 2'd2,
        K_AGE  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [BURN_W-1:0] burn;
        logic [THR_W-1:0]  thr;
    } t_cfg;

    typedef struct packed {
        t_status           status;
        logic              evalid;
        logic [FUEL_W-1:0] fuel;
        logic [EMG_W-1:0]  emg;
    } t_res;

endpackage

`default_nettype wire

FILE: hw/rtl/qpa_mem.sv
// entry store: one write port, one read port with registered read data
// uses qpa_pkg for default sizes
`default_nettype none

module qpa_mem #(
    parameter int DEPTH = qpa_pkg::DEPTH_DEF,
    parameter int WIDTH = qpa_pkg::ID_BITS_DEF + qpa_pkg::FUEL_W + qpa_pkg::EMG_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/qpa_ctrl.sv
// sequencer for the landing queue: circular buffer pointers, search,
// shift and aging passes over the entry store; instantiates qpa_mem, uses qpa_pkg
`default_nettype none

module qpa_ctrl #(
    parameter int DEPTH   = qpa_pkg::DEPTH_DEF,
    parameter int ID_BITS = qpa_pkg::ID_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    input  wire logic [qpa_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [ID_BITS-1:0]            i_flight_id,
    input  wire logic [qpa_pkg::FUEL_W-1:0]    i_fuel,
    input  wire logic [qpa_pkg::EMG_W-1:0]     i_emg,
    input  wire logic [qpa_pkg::MIN_W-1:0]     i_minutes,
    input  wire qpa_pkg::t_cfg                 i_cfg,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output qpa_pkg::t_res                      o_res,
    output logic      [ID_BITS-1:0]            o_res_id,
    output logic      [$clog2(DEPTH+1)-1:0]    o_res_count
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EW    = ID_BITS + qpa_pkg::FUEL_W + qpa_pkg::EMG_W;
    localparam int FW    = qpa_pkg::FUEL_W;
    localparam int GW    = qpa_pkg::EMG_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SRCH  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_PUT   = 6'b001000,
        S_AGE   = 6'b010000,
        S_RD    = 6'b100000
    } t_state;

    // S_RD issues the front read, the cycle after it the result is offered
    t_state                       r_state;
    logic                         r_load;
    logic [AW-1:0]                r_head;
    logic [CW-1:0]                r_occ;
    logic [AW-1:0]                r_raddr;
    qpa_pkg::t_status             r_status;
    logic                         r_evalid;
    logic [ID_BITS-1:0]           r_id;
    logic [qpa_pkg::DROP_W-1:0]   r_drop;
    logic [AW-1:0]                r_ridx;
    logic [AW-1:0]                r_widx;
    logic                         r_more;
    logic                         r_pend;
    logic [EW-1:0]                r_hold;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [EW-1:0]                mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    logic [EW-1:0]                mem_rdata;

    logic                         accept;
    logic [FW-1:0]                fuel_sat;
    logic                         last_issue;
    logic                         last_check;
    logic                         id_hit;
    logic [FW-1:0]                rd_fuel;
    logic [GW-1:0]                rd_emg;
    logic [FW-1:0]                aged_fuel;
    logic [GW-1:0]                aged_emg;

    function automatic logic [AW-1:0] slot_addr(input logic [AW-1:0] head,
                                                input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    qpa_mem #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_req_ready = (r_state == S_IDLE) && !r_load;
    assign accept      = i_req_valid && o_req_ready;
    assign fuel_sat    = (i_fuel > qpa_pkg::FUEL_MAX) ? qpa_pkg::FUEL_MAX : i_fuel;

    assign last_issue  = (CW'(r_ridx) == r_occ - CW'(1));
    assign last_check  = (CW'(r_widx) == r_occ - CW'(1));
    assign id_hit      = (mem_rdata[EW-1 -: ID_BITS] == r_id);
    assign rd_fuel     = mem_rdata[GW +: FW];
    assign rd_emg      = mem_rdata[GW-1:0];

    // fuel burn floored at zero, then low fuel marking
    always_comb begin
        if (qpa_pkg::DROP_W'(rd_fuel) > r_drop) begin
            aged_fuel = rd_fuel - r_drop[FW-1:0];
        end else begin
            aged_fuel = '0;
        end
        if ((aged_fuel < i_cfg.thr) && (rd_emg == qpa_pkg::EMG_NONE)) begin
            aged_emg = qpa_pkg::EMG_LOW;
        end else begin
            aged_emg = rd_emg;
        end
    end

    // memory port steering
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = slot_addr(r_head, r_widx);
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = slot_addr(r_head, r_ridx);
        unique case (r_state)
            S_IDLE: begin
                if (accept && (qpa_pkg::t_kind'(i_kind) == qpa_pkg::K_ENQ)
                        && (r_occ != CW'(DEPTH))) begin
                    mem_we    = 1'b1;
                    mem_waddr = slot_addr(r_head, r_occ[AW-1:0]);
                    mem_wdata = {i_flight_id, fuel_sat, i_emg};
                end
            end
            S_SRCH: begin
                mem_re = r_more;
            end
            S_SHIFT: begin
                mem_re = r_more;
                mem_we = r_pend;
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_head;
                mem_wdata = r_hold;
            end
            S_AGE: begin
                mem_re    = r_more;
                mem_we    = r_pend;
                mem_wdata = {mem_rdata[EW-1 -: ID_BITS], aged_fuel, aged_emg};
            end
            S_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_raddr;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_load  <= 1'b0;
            r_head  <= '0;
            r_occ   <= '0;
            r_more  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_load && i_res_ready) begin
                        r_load <= 1'b0;
                    end
                    if (accept) begin
                        r_raddr <= r_head;
                        r_id    <= i_flight_id;
                        r_drop  <= qpa_pkg::DROP_W'(i_minutes)
                                   * qpa_pkg::DROP_W'(i_cfg.burn);
                        r_ridx  <= '0;
                        r_more  <= 1'b1;
                        r_pend  <= 1'b0;
                        r_status <= qpa_pkg::ST_OK;
                        r_evalid <= (r_occ != '0);
                        r_state  <= S_RD;
                        unique case (qpa_pkg::t_kind'(i_kind))
                            qpa_pkg::K_ENQ: begin
                                if (r_occ == CW'(DEPTH)) begin
                                    r_status <= qpa_pkg::ST_FULL;
                                end else begin
                                    r_occ    <= r_occ + CW'(1);
                                    r_evalid <= 1'b1;
                                end
                            end
                            qpa_pkg::K_DEQ: begin
                                if (r_occ == '0) begin
                                    r_status <= qpa_pkg::ST_EMPTY;
                                end else begin
                                    r_head <= slot_addr(r_head, AW'(1));
                                    r_occ  <= r_occ - CW'(1);
                                end
                            end
                            qpa_pkg::K_PROM: begin
                                if (r_occ == '0) begin
                                    r_status <= qpa_pkg::ST_EMPTY;
                                end else begin
                                    r_state <= S_SRCH;
                                end
                            end
                            qpa_pkg::K_AGE: begin
                                if (r_occ != '0) begin
                                    r_state <= S_AGE;
                                end
                            end
                            default: begin
                                r_state <= S_RD;
                            end
                        endcase
                    end
                end
                S_SRCH: begin
                    // reads run one ahead; r_widx tags the entry in mem_rdata
                    if (r_more) begin
                        r_widx <= r_ridx;
                        if (last_issue) begin
                            r_more <= 1'b0;
                        end else begin
                            r_ridx <= r_ridx + AW'(1);
                        end
                    end
                    r_pend <= r_more;
                    if (r_pend) begin
                        if (id_hit) begin
                            r_pend <= 1'b0;
                            if (r_widx == '0) begin
                                r_more  <= 1'b0;
                                r_state <= S_RD;
                            end else begin
                                r_hold  <= mem_rdata;
                                r_ridx  <= r_widx - AW'(1);
                                r_more  <= 1'b1;
                                r_state <= S_SHIFT;
                            end
                        end else if (last_check) begin
                            r_pend   <= 1'b0;
                            r_more   <= 1'b0;
                            r_status <= qpa_pkg::ST_NOTFOUND;
                            r_state  <= S_RD;
                        end
                    end
                end
                S_SHIFT: begin
                    // read slot j-1, write it into slot j the next cycle
                    if (r_more) begin
                        r_widx <= r_ridx + AW'(1);
                        if (r_ridx == '0) begin
                            r_more <= 1'b0;
                        end else begin
                            r_ridx <= r_ridx - AW'(1);
                        end
                    end
                    r_pend <= r_more;
                    if (r_pend && !r_more) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    r_state <= S_RD;
                end
                S_AGE: begin
                    if (r_more) begin
                        r_widx <= r_ridx;
                        if (last_issue) begin
                            r_more <= 1'b0;
                        end else begin
                            r_ridx <= r_ridx + AW'(1);
                        end
                    end
                    r_pend <= r_more;
                    if (r_pend && !r_more) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_load  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result is offered while r_load is set; front read data holds meanwhile
    assign o_res_valid     = r_load;
    assign o_res.status    = r_status;
    assign o_res.evalid    = r_evalid;
    assign o_res.fuel      = r_evalid ? rd_fuel : '0;
    assign o_res.emg       = r_evalid ? rd_emg : '0;
    assign o_res_id        = r_evalid ? mem_rdata[EW-1 -: ID_BITS] : '0;
    assign o_res_count     = r_occ;

endmodule

`default_nettype wire

FILE: hw/rtl/queue_with_promote_and_aging.sv
// landing queue with promote to front and fuel aging (top level)
// sequence: enqueue and dequeue go from idle through the front read to the result; promote adds a search
// and, on a hit past the front, a shift and put pass; advance time adds one aging pass when not empty
// throughput: one request in flight, set by the single read and write port of the entry store
// reset: synchronous, clears pointers, count and output valid, config to burn 2 and threshold 20;
// the entry store is not cleared and needs no clearing pass
`default_nettype none

module queue_with_promote_and_aging #(
    parameter int DEPTH   = qpa_pkg::DEPTH_DEF,
    parameter int ID_BITS = qpa_pkg::ID_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [qpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [qpa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [qpa_pkg::KIND_W-1:0]      i_kind,
    input  wire logic [ID_BITS-1:0]              i_flight_id,
    input  wire logic [qpa_pkg::FUEL_W-1:0]      i_fuel_in,
    input  wire logic [qpa_pkg::EMG_W-1:0]       i_emergency_in,
    input  wire logic [qpa_pkg::MIN_W-1:0]       i_minutes,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [qpa_pkg::STATUS_W-1:0]    o_status,
    output logic                                 o_entry_valid,
    output logic      [ID_BITS-1:0]              o_entry_id,
    output logic      [qpa_pkg::FUEL_W-1:0]      o_entry_fuel,
    output logic      [qpa_pkg::EMG_W-1:0]       o_entry_emergency,
    output logic      [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int CW = $clog2(DEPTH + 1);

    qpa_pkg::t_cfg                 r_cfg;
    logic                          r_out_valid;
    qpa_pkg::t_res                 r_res;
    logic [ID_BITS-1:0]            r_id;
    logic [CW-1:0]                 r_count;

    logic                          res_valid;
    logic                          res_ready;
    qpa_pkg::t_res                 res;
    logic [ID_BITS-1:0]            res_id;
    logic [CW-1:0]                 res_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.burn <= qpa_pkg::BURN_RST;
            r_cfg.thr  <= qpa_pkg::THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                qpa_pkg::CFG_BURN: r_cfg.burn <= i_cfg_data[qpa_pkg::BURN_W-1:0];
                qpa_pkg::CFG_THR:  r_cfg.thr  <= i_cfg_data[qpa_pkg::THR_W-1:0];
                default:           r_cfg      <= r_cfg;
            endcase
        end
    end

    qpa_ctrl #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_kind      (i_kind),
        .i_flight_id (i_flight_id),
        .i_fuel      (i_fuel_in),
        .i_emg       (i_emergency_in),
        .i_minutes   (i_minutes),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_res_id    (res_id),
        .o_res_count (res_count)
    );

    // output register: the sequencer can take the next request while a result waits
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_res   <= res;
            r_id    <= res_id;
            r_count <= res_count;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_res.status;
    assign o_entry_valid     = r_res.evalid;
    assign o_entry_id        = r_id;
    assign o_entry_fuel      = r_res.fuel;
    assign o_entry_emergency = r_res.emg;
    assign o_count           = r_count;

endmodule

`default_nettype wire

FILE: dv/tb_queue_with_promote_and_aging.sv
// testbench for queue_with_promote_and_aging: directed table, then random phases
// under several burn and threshold settings, checked against fixed table results or an in-bench queue predictor
// depends on qpa_pkg and the queue_with_promote_and_aging rtl
`timescale 1ns / 1ps

module tb_queue_with_promote_and_aging;

    localparam int QDEPTH     = qpa_pkg::DEPTH_DEF;
    localparam int QID_W      = qpa_pkg::ID_BITS_DEF;
    localparam int FW         = qpa_pkg::FUEL_W;
    localparam int GW         = qpa_pkg::EMG_W;
    localparam int MW         = qpa_pkg::MIN_W;
    localparam int CNT_W      = $clog2(QDEPTH + 1);
    localparam int N_PHASES   = 8;
    localparam int PHASE_REQS = 245;

    typedef struct packed {
        qpa_pkg::t_kind    kind;
        logic [QID_W-1:0]  id;
        logic [FW-1:0]     fuel;
        logic [GW-1:0]     emg;
        logic [MW-1:0]     mins;
    } t_flight_req;

    typedef struct packed {
        qpa_pkg::t_status  status;
        logic              evalid;
        logic [QID_W-1:0]  id;
        logic [FW-1:0]     fuel;
        logic [GW-1:0]     emg;
        logic [CNT_W-1:0]  count;
    } t_flight_res;

    typedef struct {
        t_flight_req rq;
        int          reps;
        bit          typed;
        t_flight_res res;
    } t_dir_row;

    logic                           i_clk          = 1'b0;
    logic                           i_rst_n        = 1'b0;
    logic                           i_cfg_we       = 1'b0;
    logic [qpa_pkg::CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [qpa_pkg::CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                           i_in_valid     = 1'b0;
    logic                           o_in_ready;
    logic [qpa_pkg::KIND_W-1:0]     i_kind         = '0;
    logic [QID_W-1:0]               i_flight_id    = '0;
    logic [FW-1:0]                  i_fuel_in      = '0;
    logic [GW-1:0]                  i_emergency_in = '0;
    logic [MW-1:0]                  i_minutes      = '0;
    logic                           o_out_valid;
    logic                           i_out_ready    = 1'b0;
    logic [qpa_pkg::STATUS_W-1:0]   o_status;
    logic                           o_entry_valid;
    logic [QID_W-1:0]               o_entry_id;
    logic [FW-1:0]                  o_entry_fuel;
    logic [GW-1:0]                  o_entry_emergency;
    logic [CNT_W-1:0]               o_count;

    queue_with_promote_and_aging u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_flight_id       (i_flight_id),
        .i_fuel_in         (i_fuel_in),
        .i_emergency_in    (i_emergency_in),
        .i_minutes         (i_minutes),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_entry_valid     (o_entry_valid),
        .o_entry_id        (o_entry_id),
        .o_entry_fuel      (o_entry_fuel),
        .o_entry_emergency (o_entry_emergency),
        .o_count           (o_count)
    );

    always #6 i_clk = ~i_clk;

    // predictor state: landing queue copy, slot 0 is the front
    logic [QID_W-1:0]  lq_id   [QDEPTH];
    logic [FW-1:0]     lq_fuel [QDEPTH];
    logic [GW-1:0]     lq_emg  [QDEPTH];
    int                lq_cnt   = 0;
    int                cfg_burn = int'(qpa_pkg::BURN_RST);
    int                cfg_thr  = int'(qpa_pkg::THR_RST);

    t_flight_res landing_exp_q[$];
    t_dir_row    dir_tab[$];
    bit          no_idle = 1'b0;
    int          n_mism  = 0;
    int          n_req   = 0;
    int          n_kind[4];
    int          n_status[4];

    function automatic t_flight_res predict_landing(input t_flight_req r);
        t_flight_res       o;
        int                hit;
        int                drop;
        int                f;
        logic [QID_W-1:0]  mid;
        logic [FW-1:0]     mf;
        logic [GW-1:0]     me;
        o = '0;
        o.status = qpa_pkg::ST_OK;
        case (r.kind)
            qpa_pkg::K_ENQ: begin
                if (lq_cnt >= QDEPTH) begin
                    o.status = qpa_pkg::ST_FULL;
                end else begin
                    lq_id[lq_cnt]   = r.id;
                    lq_fuel[lq_cnt] = (r.fuel > qpa_pkg::FUEL_MAX) ? qpa_pkg::FUEL_MAX : r.fuel;
                    lq_emg[lq_cnt]  = r.emg;
                    lq_cnt++;
                end
            end
            qpa_pkg::K_DEQ: begin
                if (lq_cnt == 0) begin
                    o.status = qpa_pkg::ST_EMPTY;
                end else begin
                    o.evalid = 1'b1;
                    o.id     = lq_id[0];
                    o.fuel   = lq_fuel[0];
                    o.emg    = lq_emg[0];
                    for (int i = 1; i < lq_cnt; i++) begin
                        lq_id[i-1]   = lq_id[i];
                        lq_fuel[i-1] = lq_fuel[i];
                        lq_emg[i-1]  = lq_emg[i];
                    end
                    lq_cnt--;
                end
            end
            qpa_pkg::K_PROM: begin
                if (lq_cnt == 0) begin
                    o.status = qpa_pkg::ST_EMPTY;
                end else begin
                    hit = -1;
                    for (int i = 0; i < lq_cnt; i++)
                        if (hit < 0 && lq_id[i] == r.id) hit = i;
                    if (hit < 0) begin
                        o.status = qpa_pkg::ST_NOTFOUND;
                    end else if (hit > 0) begin
                        mid = lq_id[hit];
                        mf  = lq_fuel[hit];
                        me  = lq_emg[hit];
                        for (int i = hit; i > 0; i--) begin
                            lq_id[i]   = lq_id[i-1];
                            lq_fuel[i] = lq_fuel[i-1];
                            lq_emg[i]  = lq_emg[i-1];
                        end
                        lq_id[0]   = mid;
                        lq_fuel[0] = mf;
                        lq_emg[0]  = me;
                    end
                end
            end
            default: begin
                drop = int'(r.mins) * cfg_burn;
                for (int i = 0; i < lq_cnt; i++) begin
                    f = int'(lq_fuel[i]);
                    f = (f > drop) ? f - drop : 0;
                    lq_fuel[i] = FW'(f);
                    if (f < cfg_thr && lq_emg[i] == qpa_pkg::EMG_NONE)
                        lq_emg[i] = qpa_pkg::EMG_LOW;
                end
            end
        endcase
        // everything but dequeue reports the current front
        if (r.kind != qpa_pkg::K_DEQ && lq_cnt > 0) begin
            o.evalid = 1'b1;
            o.id     = lq_id[0];
            o.fuel   = lq_fuel[0];
            o.emg    = lq_emg[0];
        end
        o.count = CNT_W'(lq_cnt);
        return o;
    endfunction

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_req(input t_flight_req r, input bit typed, input t_flight_res tres);
        t_flight_res p;
        while (!no_idle && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= r.kind;
        i_flight_id    <= r.id;
        i_fuel_in      <= r.fuel;
        i_emergency_in <= r.emg;
        i_minutes      <= r.mins;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        p = predict_landing(r);
        landing_exp_q.push_back(typed ? tres : p);
        n_req++;
        n_kind[int'(r.kind)]++;
        @(negedge i_clk);
    endtask

    // both registers back to back, only while the queue logic is idle
    task automatic set_config(input int burn, input int thr);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= qpa_pkg::CFG_BURN;
        i_cfg_data  <= {3'($urandom_range(0, 7)), 4'(burn)};
        @(negedge i_clk);
        cfg_burn     = burn;
        i_cfg_index <= qpa_pkg::CFG_THR;
        i_cfg_data  <= 7'(thr);
        @(negedge i_clk);
        cfg_thr   = thr;
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_row(input qpa_pkg::t_kind k, input int id, input int fuel,
                           input int emg, input int mins, input int reps, input bit typed,
                           input qpa_pkg::t_status st, input bit ev, input int eid,
                           input int efuel, input int eemg, input int ecnt);
        t_dir_row row;
        row.rq.kind   = k;
        row.rq.id     = QID_W'(id);
        row.rq.fuel   = FW'(fuel);
        row.rq.emg    = GW'(emg);
        row.rq.mins   = MW'(mins);
        row.reps      = reps;
        row.typed     = typed;
        row.res.status = st;
        row.res.evalid = ev;
        row.res.id     = QID_W'(eid);
        row.res.fuel   = FW'(efuel);
        row.res.emg    = GW'(eemg);
        row.res.count  = CNT_W'(ecnt);
        dir_tab.push_back(row);
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(0, 99) >= 15);
    end

    always @(posedge i_clk) begin
        t_flight_res got;
        t_flight_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.status = qpa_pkg::t_status'(o_status);
            got.evalid = o_entry_valid;
            got.id     = o_entry_id;
            got.fuel   = o_entry_fuel;
            got.emg    = o_entry_emergency;
            got.count  = o_count;
            if (landing_exp_q.size() == 0) begin
                n_mism++;
                if (n_mism <= 10)
                    $display("[%0t] unexpected result: st=%0d ev=%0b id=%0d %s=%0d %s=%0d cnt=%0d",
                             $realtime, got.status, got.evalid, got.id, "fuel", got.fuel,
                             "emg", got.emg, got.count);
            end else begin
                want = landing_exp_q.pop_front();
                n_status[int'(want.status)]++;
                if (got !== want) begin
                    n_mism++;
                    if (n_mism <= 10) begin
                        $display("[%0t] mismatch exp: st=%0d ev=%0b id=%0d fuel=%0d",
                                 $realtime, want.status, want.evalid, want.id, want.fuel,
                                 " emg=%0d cnt=%0d", want.emg, want.count);
                        $display("[%0t]          got: st=%0d ev=%0b id=%0d fuel=%0d",
                                 $realtime, got.status, got.evalid, got.id, got.fuel,
                                 " emg=%0d cnt=%0d", got.emg, got.count);
                    end
                end
            end
        end
    end

    initial begin
        #8_000_000;
        $display("timeout with %0d results outstanding", landing_exp_q.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin : main
        int          burn_set[N_PHASES];
        int          thr_set[N_PHASES];
        t_flight_req r;
        bit          filling;
        int          pick;

        burn_set = '{0, 15, 2, 15, 0, 1, 7, 3};
        thr_set  = '{0, 127, 20, 0, 127, 100, 55, 110};
        burn_set[6] = $urandom_range(0, 15);
        thr_set[6]  = $urandom_range(0, 127);
        filling = 1'b1;
        for (int i = 0; i < 4; i++) begin
            n_kind[i]   = 0;
            n_status[i] = 0;
        end

        // directed rows at reset config (burn 2, threshold 20)
        add_row(qpa_pkg::K_DEQ,  0,     0,   0, 0,    1,  1, qpa_pkg::ST_EMPTY,
                0, 0,    0,   0, 0);
        add_row(qpa_pkg::K_PROM, 5,     0,   0, 0,    1,  1, qpa_pkg::ST_EMPTY,
                0, 0,    0,   0, 0);
        add_row(qpa_pkg::K_AGE,  0,     0,   0, 0,    1,  1, qpa_pkg::ST_OK,
                0, 0,    0,   0, 0);
        // fuel above range saturates
        add_row(qpa_pkg::K_ENQ,  1023,  127, 0, 0,    1,  1, qpa_pkg::ST_OK,
                1, 1023, 100, 0, 1);
        add_row(qpa_pkg::K_ENQ,  0,     0,   3, 1023, 1,  1, qpa_pkg::ST_OK,
                1, 1023, 100, 0, 2);
        add_row(qpa_pkg::K_ENQ,  'h2AA, 85,  2, 0,    1,  0, qpa_pkg::ST_OK,
                0, 0,    0,   0, 0);
        add_row(qpa_pkg::K_ENQ,  'h155, 42,  1, 0,    1,  0, qpa_pkg::ST_OK,
                0, 0,    0,   0, 0);
        add_row(qpa_pkg::K_ENQ,  0,     100, 0, 0,    1,  0, qpa_pkg::ST_OK,
                0, 0,    0,   0, 0);
        add_row(qpa_pkg::K_PROM, 777,   0,   0, 0,    1,  1, qpa_pkg::ST_NOTFOUND,
                1, 1023, 100, 0, 5);
        add_row(qpa_pkg::K_PROM, 1023,  0,   0, 0,    1,  1, qpa_pkg::ST_OK,
                1, 1023, 100, 0, 5);
        // two entries share id 0, the one nearer the front moves
        add_row(qpa_pkg::K_PROM, 0,     0,   0, 0,    1,  0, qpa_pkg::ST_OK,
                0, 0,    0,   0, 0);
        add_row(qpa_pkg::K_AGE,  0,     0,   0, 0,    1,  0, qpa_pkg::ST_OK,
                0, 0,    0,   0, 0);
        add_row(qpa_pkg::K_AGE,  0,     0,   0, 30,   1,  0, qpa_pkg::ST_OK,
                0, 0,    0,   0, 0);
        add_row(qpa_pkg::K_DEQ,  0,     0,   0, 0,    1,  0, qpa_pkg::ST_OK,
                0, 0,    0,   0, 0);
        add_row(qpa_pkg::K_ENQ,  'h3C0, 101, 0, 0,    12, 0, qpa_pkg::ST_OK,
                0, 0,    0,   0, 0);
        add_row(qpa_pkg::K_ENQ,  9,     50,  1, 0,    1,  0, qpa_pkg::ST_OK,
                0, 0,    0,   0, 0);
        add_row(qpa_pkg::K_PROM, 'h3C0, 0,   0, 0,    1,  0, qpa_pkg::ST_OK,
                0, 0,    0,   0, 0);
        add_row(qpa_pkg::K_AGE,  0,     0,   0, 1023, 1,  0, qpa_pkg::ST_OK,
                0, 0,    0,   0, 0);
        add_row(qpa_pkg::K_DEQ,  0,     0,   0, 0,    16, 0, qpa_pkg::ST_OK,
                0, 0,    0,   0, 0);
        add_row(qpa_pkg::K_DEQ,  0,     0,   0, 0,    1,  1, qpa_pkg::ST_EMPTY,
                0, 0,    0,   0, 0);
        add_row(qpa_pkg::K_AGE,  0,     0,   0, 1023, 1,  1, qpa_pkg::ST_OK,
                0, 0,    0,   0, 0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[n])
            for (int k = 0; k < dir_tab[n].reps; k++)
                send_req(dir_tab[n].rq, dir_tab[n].typed, dir_tab[n].res);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // drain fully before touching the registers
            i_in_valid <= 1'b0;
            while (landing_exp_q.size() != 0) @(negedge i_clk);
            set_config(burn_set[ph], thr_set[ph]);
            no_idle = (ph == 2);
            for (int n = 0; n < PHASE_REQS; n++) begin
                if (lq_cnt >= QDEPTH) filling = 1'b0;
                else if (lq_cnt == 0) filling = 1'b1;
                else if ($urandom_range(0, 99) < 3) filling = !filling;

                r.id   = QID_W'($urandom_range(0, 1023));
                r.emg  = GW'($urandom_range(0, 3));
                r.fuel = ($urandom_range(0, 99) < 85) ? FW'($urandom_range(0, 100))
                                                      : FW'($urandom_range(0, 127));
                pick = $urandom_range(0, 99);
                if (pick < 70)      r.mins = MW'($urandom_range(0, 5));
                else if (pick < 90) r.mins = MW'($urandom_range(0, 40));
                else                r.mins = MW'($urandom_range(0, 1023));

                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    r.kind = qpa_pkg::t_kind'($urandom_range(0, 3));
                end else if (filling) begin
                    if (pick < 55)      r.kind = qpa_pkg::K_ENQ;
                    else if (pick < 68) r.kind = qpa_pkg::K_DEQ;
                    else if (pick < 88) r.kind = qpa_pkg::K_PROM;
                    else                r.kind = qpa_pkg::K_AGE;
                end else begin
                    if (pick < 22)      r.kind = qpa_pkg::K_ENQ;
                    else if (pick < 60) r.kind = qpa_pkg::K_DEQ;
                    else if (pick < 85) r.kind = qpa_pkg::K_PROM;
                    else                r.kind = qpa_pkg::K_AGE;
                end
                // small id pool makes duplicates; promotes mostly target a held id
                if (r.kind == qpa_pkg::K_ENQ && $urandom_range(0, 99) < 30)
                    r.id = QID_W'($urandom_range(0, 7));
                if (r.kind == qpa_pkg::K_PROM && lq_cnt > 0 && $urandom_range(0, 99) < 65)
                    r.id = lq_id[$urandom_range(0, lq_cnt - 1)];

                send_req(r, 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        no_idle = 1'b0;
        while (landing_exp_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("covered %0d requests: %0d enqueue, %0d dequeue, %0d promote, %0d advance",
                 n_req, n_kind[int'(qpa_pkg::K_ENQ)], n_kind[int'(qpa_pkg::K_DEQ)],
                 n_kind[int'(qpa_pkg::K_PROM)], n_kind[int'(qpa_pkg::K_AGE)]);
        $display("over %0d register settings; status seen ok %0d empty %0d full %0d absent %0d",
                 N_PHASES + 1, n_status[int'(qpa_pkg::ST_OK)],
                 n_status[int'(qpa_pkg::ST_EMPTY)], n_status[int'(qpa_pkg::ST_FULL)],
                 n_status[int'(qpa_pkg::ST_NOTFOUND)]);
        if (n_mism == 0 && landing_exp_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d results missing", n_mism, landing_exp_q.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
